/* design/pse_pkg.sv */
package pse_pkg;

  localparam int MAX_JOBS = 16;

  // fixed field widths of the channels
  localparam int BURST_W = 16;
  localparam int ARR_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int NUM_W   = 5;
  localparam int TIME_W  = 21;
  localparam int SUM_W   = 25;
  localparam int COUNT_W = 5;

  // job counter holds 0 .. MAX_JOBS
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  // schedule clock never exceeds (MAX_JOBS + 1) full bursts
  localparam int CLK_W = BURST_W + CNT_W;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [CNT_W-1:0]   number;
  } job_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic             step;
    logic             last;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } sched_ctrl_t;

endpackage

/* design/pse_if.sv */
interface pse_in_if;
  logic                         valid;
  logic                         ready;
  logic [pse_pkg::BURST_W-1:0]  burst_time;
  logic [pse_pkg::ARR_W-1:0]    arrival_time;
  logic [pse_pkg::PRIO_W-1:0]   priority_level;
  logic                         last_job;

  modport source (output valid, burst_time, arrival_time, priority_level, last_job,
                  input ready);
  modport sink (input valid, burst_time, arrival_time, priority_level, last_job,
                output ready);
endinterface

interface pse_out_if;
  logic                         valid;
  logic                         ready;
  logic [pse_pkg::NUM_W-1:0]    job_number;
  logic [pse_pkg::PRIO_W-1:0]   job_priority;
  logic [pse_pkg::ARR_W-1:0]    job_arrival;
  logic [pse_pkg::BURST_W-1:0]  job_burst;
  logic [pse_pkg::TIME_W-1:0]   wait_time;
  logic [pse_pkg::TIME_W-1:0]   turnaround_time;
  logic [pse_pkg::SUM_W-1:0]    wait_sum;
  logic [pse_pkg::SUM_W-1:0]    turnaround_sum;
  logic [pse_pkg::COUNT_W-1:0]  job_count;
  logic                         overflow_flag;
  logic                         last_result;

  modport source (output valid, job_number, job_priority, job_arrival, job_burst,
                  wait_time, turnaround_time, wait_sum, turnaround_sum, job_count,
                  overflow_flag, last_result,
                  input ready);
  modport sink (input valid, job_number, job_priority, job_arrival, job_burst,
                wait_time, turnaround_time, wait_sum, turnaround_sum, job_count,
                overflow_flag, last_result,
                output ready);
endinterface

/* design/pse_cell.sv */
module pse_cell (
  input  logic               clk,
  input  pse_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  pse_pkg::job_t      new_job,
  input  logic               prev_ahead,
  input  pse_pkg::job_t      prev_job,
  input  pse_pkg::job_t      next_job,
  output logic               ahead,
  output pse_pkg::job_t      job
);

  pse_pkg::job_t job_r;
  pse_pkg::job_t job_nxt;
  logic          strictly_first;

  // later request wins only on strictly smaller key, so full ties keep load order
  always_comb begin
    if (new_job.prio != job_r.prio) begin
      strictly_first = (new_job.prio < job_r.prio);
    end else begin
      strictly_first = (new_job.arrival < job_r.arrival);
    end
  end

  // an empty cell sorts after everything
  assign ahead = !occ || strictly_first;

  always_comb begin
    job_nxt = job_r;
    if (ctrl.shift) begin
      job_nxt = next_job;
    end else if (ctrl.insert) begin
      if (prev_ahead) begin
        job_nxt = prev_job;
      end else if (ahead) begin
        job_nxt = new_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job = job_r;

endmodule

/* design/pse_sched.sv */
module pse_sched (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pse_pkg::sched_ctrl_t ctrl,
  input  pse_pkg::job_t        head,
  output logic                 slot_free,
  pse_out_if.source            out_ch
);

  logic [pse_pkg::CLK_W-1:0] clock_r, clock_nxt;
  logic [pse_pkg::SUM_W-1:0] wsum_r, wsum_nxt;
  logic [pse_pkg::SUM_W-1:0] tsum_r, tsum_nxt;
  logic [pse_pkg::CLK_W:0]   diff;
  logic                      idle_gap;
  logic [pse_pkg::CLK_W-1:0] arr_ext;
  logic [pse_pkg::CLK_W-1:0] burst_ext;
  logic [pse_pkg::CLK_W-1:0] start;
  logic [pse_pkg::CLK_W-1:0] wait_v;
  logic [pse_pkg::CLK_W-1:0] turn_v;

  logic                        valid_r;
  logic [pse_pkg::NUM_W-1:0]   num_r;
  logic [pse_pkg::PRIO_W-1:0]  prio_r;
  logic [pse_pkg::ARR_W-1:0]   arr_r;
  logic [pse_pkg::BURST_W-1:0] burst_r;
  logic [pse_pkg::TIME_W-1:0]  wait_r;
  logic [pse_pkg::TIME_W-1:0]  turn_r;
  logic [pse_pkg::SUM_W-1:0]   wsum_out_r;
  logic [pse_pkg::SUM_W-1:0]   tsum_out_r;
  logic [pse_pkg::COUNT_W-1:0] count_r;
  logic                        ovf_r;
  logic                        last_r;

  assign arr_ext   = pse_pkg::CLK_W'(head.arrival);
  assign burst_ext = pse_pkg::CLK_W'(head.burst);

  // borrow of clock - arrival tells the processor sat idle until the arrival
  assign diff      = {1'b0, clock_r} - {1'b0, arr_ext};
  assign idle_gap  = diff[pse_pkg::CLK_W];
  assign wait_v    = idle_gap ? '0 : diff[pse_pkg::CLK_W-1:0];
  assign start     = idle_gap ? arr_ext : clock_r;
  assign clock_nxt = start + burst_ext;
  assign turn_v    = wait_v + burst_ext;
  assign wsum_nxt  = wsum_r + pse_pkg::SUM_W'(wait_v);
  assign tsum_nxt  = tsum_r + pse_pkg::SUM_W'(turn_v);

  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      wsum_r  <= '0;
      tsum_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (ctrl.step) begin
        valid_r <= 1'b1;
        // clear the totals after the final job of a set
        if (ctrl.last) begin
          clock_r <= '0;
          wsum_r  <= '0;
          tsum_r  <= '0;
        end else begin
          clock_r <= clock_nxt;
          wsum_r  <= wsum_nxt;
          tsum_r  <= tsum_nxt;
        end
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      num_r      <= pse_pkg::NUM_W'(head.number);
      prio_r     <= head.prio;
      arr_r      <= head.arrival;
      burst_r    <= head.burst;
      wait_r     <= pse_pkg::TIME_W'(wait_v);
      turn_r     <= pse_pkg::TIME_W'(turn_v);
      count_r    <= pse_pkg::COUNT_W'(ctrl.count);
      ovf_r      <= ctrl.overflow;
      last_r     <= ctrl.last;
      wsum_out_r <= wsum_nxt;
      tsum_out_r <= tsum_nxt;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.job_number      = num_r;
  assign out_ch.job_priority    = prio_r;
  assign out_ch.job_arrival     = arr_r;
  assign out_ch.job_burst       = burst_r;
  assign out_ch.wait_time       = wait_r;
  assign out_ch.turnaround_time = turn_r;
  assign out_ch.wait_sum        = wsum_out_r;
  assign out_ch.turnaround_sum  = tsum_out_r;
  assign out_ch.job_count       = count_r;
  assign out_ch.overflow_flag   = ovf_r;
  assign out_ch.last_result     = last_r;

endmodule

/* design/priority_schedule_evaluator.sv */
// channel   dir  handshake     payload
// in_ch     in   valid/ready   burst_time, arrival_time, priority_level, last_job
// out_ch    out  valid/ready   job_number .. last_result, one per held job
//
// loading takes one request per cycle; each job is placed at once into a sorted
// chain of MAX_JOBS cells, compared against every held job in the same cycle,
// or dropped if the chain is full. the request with last_job closes the set;
// then the chain shifts one job per cycle into the schedule stage while out_ch
// does not stall. in_ch is not ready while a set is being emitted.
// rst_n is synchronous, active low; it empties the set and the output register.
module priority_schedule_evaluator (
  input logic         clk,
  input logic         rst_n,
  pse_in_if.sink      in_ch,
  pse_out_if.source   out_ch
);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t                      state_r;
  logic [pse_pkg::CNT_W-1:0]   cnt_r;
  logic [pse_pkg::CNT_W-1:0]   remain_r;
  logic                        dropped_r;

  logic                        accept;
  logic                        room;
  logic                        slot_free;
  logic                        step;
  pse_pkg::job_t               new_job;
  pse_pkg::cell_ctrl_t         cell_ctrl;
  pse_pkg::sched_ctrl_t        sched_ctrl;

  pse_pkg::job_t               cell_job  [pse_pkg::MAX_JOBS];
  logic                        cell_bef  [pse_pkg::MAX_JOBS];
  logic                        cell_occ  [pse_pkg::MAX_JOBS];

  assign in_ch.ready = (state_r == ST_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = (cnt_r < pse_pkg::CNT_W'(pse_pkg::MAX_JOBS));
  assign step        = (state_r == ST_EMIT) && slot_free;

  assign new_job.prio    = in_ch.priority_level;
  assign new_job.arrival = in_ch.arrival_time;
  assign new_job.burst   = in_ch.burst_time;
  assign new_job.number  = cnt_r + 1'b1;

  assign cell_ctrl.insert = accept && room;
  assign cell_ctrl.shift  = step;

  assign sched_ctrl.step     = step;
  assign sched_ctrl.last     = (remain_r == pse_pkg::CNT_W'(1));
  assign sched_ctrl.count    = cnt_r;
  assign sched_ctrl.overflow = dropped_r;

  for (genvar g = 0; g < pse_pkg::MAX_JOBS; g++) begin : g_cell
    assign cell_occ[g] = (cnt_r > pse_pkg::CNT_W'(g));
    if (g == 0) begin : g_head
      pse_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .occ        (cell_occ[g]),
        .new_job    (new_job),
        .prev_ahead (1'b0),
        .prev_job   (new_job),
        .next_job   (cell_job[(g + 1) % pse_pkg::MAX_JOBS]),
        .ahead      (cell_bef[g]),
        .job        (cell_job[g])
      );
    end else if (g == pse_pkg::MAX_JOBS - 1) begin : g_tail
      pse_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .occ        (cell_occ[g]),
        .new_job    (new_job),
        .prev_ahead (cell_bef[g - 1]),
        .prev_job   (cell_job[g - 1]),
        .next_job   (new_job),
        .ahead      (cell_bef[g]),
        .job        (cell_job[g])
      );
    end else begin : g_mid
      pse_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .occ        (cell_occ[g]),
        .new_job    (new_job),
        .prev_ahead (cell_bef[g - 1]),
        .prev_job   (cell_job[g - 1]),
        .next_job   (cell_job[g + 1]),
        .ahead      (cell_bef[g]),
        .job        (cell_job[g])
      );
    end
  end

  pse_sched u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (sched_ctrl),
    .head      (cell_job[0]),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      remain_r  <= '0;
      dropped_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_ch.last_job) begin
              state_r  <= ST_EMIT;
              remain_r <= room ? cnt_r + 1'b1 : cnt_r;
            end
          end
        end
        ST_EMIT: begin
          if (step) begin
            remain_r <= remain_r - 1'b1;
            if (sched_ctrl.last) begin
              state_r   <= ST_LOAD;
              cnt_r     <= '0;
              dropped_r <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

/* design/pse_checker.sv */
module pse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last_job,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_last_result,
  input logic [pse_pkg::BURST_W-1:0] out_job_burst,
  input logic [pse_pkg::TIME_W-1:0]  out_wait_time,
  input logic [pse_pkg::TIME_W-1:0]  out_turnaround_time,
  input logic [pse_pkg::SUM_W-1:0]   out_wait_sum
);

  // closing a set always yields at least one result, so loading pauses
  a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_job |=> !in_ready)
    else $error("input still ready after a set was closed");

  // results of one set come back to back once taken
  a_set_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=> out_valid)
    else $error("gap inside a set of results");

  a_turnaround: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_turnaround_time ==
      pse_pkg::TIME_W'(out_wait_time + pse_pkg::TIME_W'(out_job_burst)))
    else $error("turnaround is not wait plus burst");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_wait_sum)
      && $stable(out_last_result))
    else $error("stalled result changed");

endmodule

bind priority_schedule_evaluator pse_checker u_pse_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_last_job         (in_ch.last_job),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_last_result     (out_ch.last_result),
  .out_job_burst       (out_ch.job_burst),
  .out_wait_time       (out_ch.wait_time),
  .out_turnaround_time (out_ch.turnaround_time),
  .out_wait_sum        (out_ch.wait_sum)
);
